// File: design/euler_trs_chain_compose_macros.svh
// ---------------------------------------------------------------------------
// Euler TRS chain compose assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef EULER_TRS_CHAIN_COMPOSE_MACROS_SVH
`define EULER_TRS_CHAIN_COMPOSE_MACROS_SVH

// same-cycle implication, off during reset
`define ETC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etc assertion failed");

// next-cycle implication, off during reset
`define ETC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etc assertion failed");

// next-cycle implication, always on
`define ETC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("etc reset assertion failed");

`endif

// File: design/etc_pkg.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose package
// Widths, constants and helper functions shared by the block.
// ---------------------------------------------------------------------------
package etc_pkg;

  localparam int MW     = 34;
  localparam int PW     = 2 * MW;

  localparam logic [30:0] PI_Q29   = 31'd1686629713;
  localparam logic [30:0] ONE_Q30  = 31'd1073741824;
  localparam logic [14:0] QUARTER  = 15'd16384;

  localparam logic signed [PW-1:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [PW-1:0] S32_MIN = -68'sd2147483648;
  localparam logic signed [PW-1:0] S16_MAX = 68'sd32767;
  localparam logic signed [PW-1:0] S16_MIN = -68'sd32768;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] a);
    if (a > S32_MAX) sat32 = 32'sh7fffffff;
    else if (a < S32_MIN) sat32 = 32'sh80000000;
    else sat32 = a[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] a);
    if (a > S16_MAX) sat16 = 16'sh7fff;
    else if (a < S16_MIN) sat16 = 16'sh8000;
    else sat16 = a[15:0];
  endfunction

endpackage

// File: design/etc_if.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose channels
// Valid/ready channels for local transforms in and world transforms out.
// ---------------------------------------------------------------------------
interface etc_in_if;
  logic               valid;
  logic               ready;
  logic               start_req;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        angle_x;
  logic [15:0]        angle_y;
  logic [15:0]        angle_z;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] scale_z;

  modport source (output valid, start_req, pos_x, pos_y, pos_z, angle_x, angle_y,
                  angle_z, scale_x, scale_y, scale_z, input ready);
  modport sink   (input valid, start_req, pos_x, pos_y, pos_z, angle_x, angle_y,
                  angle_z, scale_x, scale_y, scale_z, output ready);
endinterface

interface etc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_pos_x;
  logic signed [31:0] world_pos_y;
  logic signed [31:0] world_pos_z;
  logic [15:0]        world_angle_x;
  logic [15:0]        world_angle_y;
  logic [15:0]        world_angle_z;
  logic signed [15:0] world_scale_x;
  logic signed [15:0] world_scale_y;
  logic signed [15:0] world_scale_z;

  modport source (output valid, world_pos_x, world_pos_y, world_pos_z, world_angle_x,
                  world_angle_y, world_angle_z, world_scale_x, world_scale_y,
                  world_scale_z, input ready);
  modport sink   (input valid, world_pos_x, world_pos_y, world_pos_z, world_angle_x,
                  world_angle_y, world_angle_z, world_scale_x, world_scale_y,
                  world_scale_z, output ready);
endinterface

// File: design/etc_mul.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose shared multiplier
// Signed multiplier with a registered product, shared by all steps.
// ---------------------------------------------------------------------------
module etc_mul (
  input  logic                           clk,
  input  logic signed [etc_pkg::MW-1:0]  a,
  input  logic signed [etc_pkg::MW-1:0]  b,
  output logic signed [etc_pkg::PW-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: design/etc_div.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose Horner divider
// Division by the Horner constants 2k(2k+1) through a reciprocal multiply on
// the shared multiplier; exact for dividends below 2^32.
// ---------------------------------------------------------------------------
module etc_div (
  input  logic [3:0]                     k,
  input  logic signed [etc_pkg::PW-1:0]  prod,
  output logic signed [etc_pkg::MW-1:0]  recip,
  output logic [30:0]                    quotient
);

  logic [5:0] sh;

  // recip = ceil(2^sh / d), sh = 32 + ceil(log2(d))
  always_comb begin
    case (k)
      4'd8:    begin recip = 34'sd8084644322; sh = 6'd41; end
      4'd7:    begin recip = 34'sd5235769657; sh = 6'd40; end
      4'd6:    begin recip = 34'sd7048151461; sh = 6'd40; end
      4'd5:    begin recip = 34'sd4997780127; sh = 6'd39; end
      4'd4:    begin recip = 34'sd7635497416; sh = 6'd39; end
      4'd3:    begin recip = 34'sd6544712071; sh = 6'd38; end
      4'd2:    begin recip = 34'sd6871947674; sh = 6'd37; end
      default: begin recip = 34'sd5726623062; sh = 6'd35; end
    endcase
    quotient = 31'(prod >> sh);
  end

endmodule

// File: design/euler_trs_chain_compose.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose
// Accumulates translate-rotate-scale transforms from chain root to leaf.
// ---------------------------------------------------------------------------
// Start item: goes from the input transfer straight to the hand-off, which takes the
// input as the new world transform. Compose item: position and scale products for
// each axis, six sines (eight multiply, reciprocal and update steps each), the
// rotation and the hand-off. One item at a time, input not ready meanwhile; a held
// result stalls the sequencer. Synchronous reset loads the identity transform and
// empties the output.
module euler_trs_chain_compose #(
  parameter int TRIG_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  etc_in_if.sink    in_ch,
  etc_out_if.source out_ch
);

  localparam int TW     = TRIG_BITS + 2;
  localparam int RND_SH = 30 - TRIG_BITS;
  localparam int MW     = etc_pkg::MW;
  localparam int PW     = etc_pkg::PW;

  typedef enum logic [4:0] {
    S_IDLE, S_VMUL, S_VRES, S_SMUL, S_SRES, T_X, T_X2, T_X2R, T_HM, T_HD, T_HW,
    T_S, T_SR, R_M1, R_M2, R_C, S_FIN
  } state_t;

  state_t state;
  logic [1:0] j, ti, st, u, w;
  logic       th, o, start_r, ov;
  logic [3:0] k;

  logic signed [31:0] ipos [3];
  logic signed [31:0] apos [3];
  logic [15:0]        iang [3];
  logic [15:0]        aang [3];
  logic [15:0]        nang [3];
  logic signed [15:0] iscl [3];
  logic signed [15:0] ascl [3];
  logic signed [15:0] nscl [3];
  logic signed [31:0] npos [3];
  logic signed [MW-1:0] v [3];
  logic signed [MW-1:0] ra;
  logic signed [TW-1:0] sn [3];
  logic signed [TW-1:0] cs [3];
  logic [TRIG_BITS:0]   qp;
  logic [30:0] x, t;
  logic [31:0] x2;
  logic signed [PW-1:0] p1;

  logic signed [31:0] opos [3];
  logic [15:0]        oang [3];
  logic signed [15:0] oscl [3];

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [MW-1:0] div_recip;
  logic [30:0]          div_q;

  logic [13:0]          r14;
  logic [14:0]          rr;
  logic signed [PW-1:0] rsum, rres, rs8;
  logic [32:0]          sv, trnd;
  logic [TRIG_BITS:0]   tval;
  logic signed [TW-1:0] tps, tms;

  etc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  etc_div u_div (.k(k), .prod(prod), .recip(div_recip), .quotient(div_q));

  always_comb begin
    r14 = aang[ti][13:0];
    rr  = th ? (etc_pkg::QUARTER - {1'b0, r14}) : {1'b0, r14};
    case (st)
      2'd0:    begin u = 2'd1; w = 2'd2; end
      2'd1:    begin u = 2'd2; w = 2'd0; end
      default: begin u = 2'd0; w = 2'd1; end
    endcase
    rsum = o ? (p1 + prod) : (p1 - prod);
    rres = (rsum + (PW'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
    rs8  = (prod + 68'sd128) >>> 8;
    sv   = prod[62:30];
    trnd = (sv + (33'd1 << (RND_SH - 1))) >> RND_SH;
    tval = (trnd > (33'd1 << TRIG_BITS)) ? (TRIG_BITS + 1)'(1 << TRIG_BITS)
                                         : trnd[TRIG_BITS:0];
    tps  = TW'(qp);
    tms  = TW'(tval);
    for (int i = 0; i < 3; i++) begin
      npos[i] = etc_pkg::sat32(PW'(apos[i]) + PW'(v[i]));
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_VMUL: begin ma = MW'(ipos[j]); mb = MW'(ascl[j]); end
      S_SMUL: begin ma = MW'(ascl[j]); mb = MW'(iscl[j]); end
      T_X:    begin ma = MW'(rr); mb = MW'(etc_pkg::PI_Q29); end
      T_X2:   begin ma = MW'(prod[44:14]); mb = MW'(prod[44:14]); end
      T_HM:   begin ma = MW'(x2); mb = MW'(t); end
      T_HD:   begin ma = MW'(prod[61:30]); mb = div_recip; end
      T_S:    begin ma = MW'(x); mb = MW'(t); end
      R_M1:   begin ma = v[u]; mb = o ? MW'(sn[st]) : MW'(cs[st]); end
      R_M2:   begin ma = v[w]; mb = o ? MW'(cs[st]) : MW'(sn[st]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = ov;
  assign out_ch.world_pos_x   = opos[0];
  assign out_ch.world_pos_y   = opos[1];
  assign out_ch.world_pos_z   = opos[2];
  assign out_ch.world_angle_x = oang[0];
  assign out_ch.world_angle_y = oang[1];
  assign out_ch.world_angle_z = oang[2];
  assign out_ch.world_scale_x = oscl[0];
  assign out_ch.world_scale_y = oscl[1];
  assign out_ch.world_scale_z = oscl[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ov      <= 1'b0;
      start_r <= 1'b0;
      j <= '0; ti <= '0; st <= '0; th <= 1'b0; o <= 1'b0; k <= 4'd8;
      for (int i = 0; i < 3; i++) begin
        apos[i] <= '0;
        aang[i] <= '0;
        ascl[i] <= 16'sd256;
      end
    end else begin
      if (state == S_FIN && (!ov || out_ch.ready)) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            start_r <= in_ch.start_req;
            ipos[0] <= in_ch.pos_x;   ipos[1] <= in_ch.pos_y;   ipos[2] <= in_ch.pos_z;
            iang[0] <= in_ch.angle_x; iang[1] <= in_ch.angle_y; iang[2] <= in_ch.angle_z;
            iscl[0] <= in_ch.scale_x; iscl[1] <= in_ch.scale_y; iscl[2] <= in_ch.scale_z;
            j       <= '0;
            state   <= in_ch.start_req ? S_FIN : S_VMUL;
          end
        end
        S_VMUL: state <= S_VRES;
        S_VRES: begin
          v[j]  <= MW'(etc_pkg::sat32(rs8));
          state <= S_SMUL;
        end
        S_SMUL: state <= S_SRES;
        S_SRES: begin
          nscl[j] <= etc_pkg::sat16(rs8);
          nang[j] <= aang[j] + iang[j];
          if (j == 2'd2) begin
            j     <= '0;
            ti    <= '0;
            th    <= 1'b0;
            state <= T_X;
          end else begin
            j     <= j + 1'b1;
            state <= S_VMUL;
          end
        end
        T_X:  state <= T_X2;
        T_X2: begin
          x     <= prod[44:14];
          state <= T_X2R;
        end
        T_X2R: begin
          x2    <= prod[61:30];
          t     <= etc_pkg::ONE_Q30;
          k     <= 4'd8;
          state <= T_HM;
        end
        T_HM: state <= T_HD;
        T_HD: state <= T_HW;
        T_HW: begin
          t <= etc_pkg::ONE_Q30 - div_q;
          if (k == 4'd1) begin
            state <= T_S;
          end else begin
            k     <= k - 1'b1;
            state <= T_HM;
          end
        end
        T_S: state <= T_SR;
        T_SR: begin
          if (!th) begin
            qp    <= tval;
            th    <= 1'b1;
            state <= T_X;
          end else begin
            case (aang[ti][15:14])
              2'd0:    begin sn[ti] <= tps;  cs[ti] <= tms;  end
              2'd1:    begin sn[ti] <= tms;  cs[ti] <= -tps; end
              2'd2:    begin sn[ti] <= -tps; cs[ti] <= -tms; end
              default: begin sn[ti] <= -tms; cs[ti] <= tps;  end
            endcase
            th <= 1'b0;
            if (ti == 2'd2) begin
              st    <= '0;
              o     <= 1'b0;
              state <= R_M1;
            end else begin
              ti    <= ti + 1'b1;
              state <= T_X;
            end
          end
        end
        R_M1: state <= R_M2;
        R_M2: begin
          p1    <= prod;
          state <= R_C;
        end
        R_C: begin
          if (!o) begin
            ra    <= rres[MW-1:0];
            o     <= 1'b1;
            state <= R_M1;
          end else begin
            v[u] <= ra;
            v[w] <= rres[MW-1:0];
            o    <= 1'b0;
            if (st == 2'd2) begin
              state <= S_FIN;
            end else begin
              st    <= st + 1'b1;
              state <= R_M1;
            end
          end
        end
        S_FIN: begin
          if (!ov || out_ch.ready) begin
            for (int i = 0; i < 3; i++) begin
              apos[i] <= start_r ? ipos[i] : npos[i];
              aang[i] <= start_r ? iang[i] : nang[i];
              ascl[i] <= start_r ? iscl[i] : nscl[i];
              opos[i] <= start_r ? ipos[i] : npos[i];
              oang[i] <= start_r ? iang[i] : nang[i];
              oscl[i] <= start_r ? iscl[i] : nscl[i];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/etc_check.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose checker
// Port-level assertions on the transfer sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`include "euler_trs_chain_compose_macros.svh"

module etc_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `ETC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ETC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  `ETC_ASSERT_NOW(a_known_hs, 1'b1, !$isunknown({in_ready, out_valid}))
  `ETC_ASSERT_RST(a_reset_empty, rst, !out_valid && in_ready)

endmodule

bind euler_trs_chain_compose etc_check u_etc_check (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

// File: bench/etc_checker.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose checker
// Watches both channels, keeps its own world transform and predicts each
// result, then compares every output transfer field by field.
// ---------------------------------------------------------------------------
module etc_checker #(
  parameter int TRIG_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  etc_in_if    in_ch,
  etc_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam longint unsigned PI_Q29  = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam int unsigned     QUARTER = 16384;
  localparam longint          S32_MAX = 64'sd2147483647;
  localparam longint          S32_MIN = -64'sd2147483648;
  localparam longint          S16_MAX = 64'sd32767;
  localparam longint          S16_MIN = -64'sd32768;

  typedef struct {
    logic signed [31:0] pos [3];
    logic [15:0]        ang [3];
    logic signed [15:0] scl [3];
  } world_t;

  world_t world;
  world_t world_q [$];

  function automatic longint rnd_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint quarter_sin(int unsigned r);
    longint unsigned x, x2, t;
    longint          s;
    x  = (64'(r) * PI_Q29) >> 14;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int k = 8; k >= 1; k--) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
    end
    s = longint'((x * t) >> 30);
    s = rnd_shift(s, 30 - TRIG_BITS);
    return clip(s, 0, longint'(1) <<< TRIG_BITS);
  endfunction

  task automatic sin_cos(input logic [15:0] a, output longint sn, output longint cs);
    int unsigned r;
    longint      p, m;
    r = 32'(a[13:0]);
    p = quarter_sin(r);
    m = quarter_sin(QUARTER - r);
    case (a[15:14])
      2'd0: begin sn = p;  cs = m;  end
      2'd1: begin sn = m;  cs = -p; end
      2'd2: begin sn = -p; cs = -m; end
      default: begin sn = -m; cs = p; end
    endcase
  endtask

  task automatic predict_world();
    longint v [3], sn [3], cs [3];
    longint a, b;
    logic signed [31:0] lp [3];
    logic [15:0]        la [3];
    logic signed [15:0] ls [3];
    lp = '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
    la = '{in_ch.angle_x, in_ch.angle_y, in_ch.angle_z};
    ls = '{in_ch.scale_x, in_ch.scale_y, in_ch.scale_z};
    if (in_ch.start_req) begin
      world.pos = lp;
      world.ang = la;
      world.scl = ls;
    end else begin
      for (int i = 0; i < 3; i++) begin
        v[i] = clip(rnd_shift(longint'(lp[i]) * longint'(world.scl[i]), 8),
                    S32_MIN, S32_MAX);
        sin_cos(world.ang[i], sn[i], cs[i]);
      end
      a = rnd_shift(v[1] * cs[0] - v[2] * sn[0], TRIG_BITS);
      b = rnd_shift(v[1] * sn[0] + v[2] * cs[0], TRIG_BITS);
      v[1] = a; v[2] = b;
      a = rnd_shift(v[0] * cs[1] + v[2] * sn[1], TRIG_BITS);
      b = rnd_shift(v[2] * cs[1] - v[0] * sn[1], TRIG_BITS);
      v[0] = a; v[2] = b;
      a = rnd_shift(v[0] * cs[2] - v[1] * sn[2], TRIG_BITS);
      b = rnd_shift(v[0] * sn[2] + v[1] * cs[2], TRIG_BITS);
      v[0] = a; v[1] = b;
      for (int i = 0; i < 3; i++) begin
        world.pos[i] = 32'(clip(longint'(world.pos[i]) + v[i], S32_MIN, S32_MAX));
        world.ang[i] = world.ang[i] + la[i];
        world.scl[i] = 16'(clip(rnd_shift(longint'(world.scl[i]) * longint'(ls[i]), 8),
                                S16_MIN, S16_MAX));
      end
    end
    world_q.insert(world_q.size(), world);
  endtask

  task automatic check_world();
    world_t exp_w;
    logic signed [31:0] gp [3];
    logic [15:0]        ga [3];
    logic signed [15:0] gs [3];
    string axis [3];
    axis = '{"x", "y", "z"};
    gp = '{out_ch.world_pos_x, out_ch.world_pos_y, out_ch.world_pos_z};
    ga = '{out_ch.world_angle_x, out_ch.world_angle_y, out_ch.world_angle_z};
    gs = '{out_ch.world_scale_x, out_ch.world_scale_y, out_ch.world_scale_z};
    if (world_q.size() == 0) begin
      $error("unexpected output transfer");
      fail_count++;
      return;
    end
    exp_w = world_q.pop_front();
    for (int i = 0; i < 3; i++) begin
      if (gp[i] !== exp_w.pos[i]) begin
        $error("world_pos_%s expected %0d actual %0d", axis[i], exp_w.pos[i], gp[i]);
        fail_count++;
      end
      if (ga[i] !== exp_w.ang[i]) begin
        $error("world_angle_%s expected %0d actual %0d", axis[i], exp_w.ang[i], ga[i]);
        fail_count++;
      end
      if (gs[i] !== exp_w.scl[i]) begin
        $error("world_scale_%s expected %0d actual %0d", axis[i], exp_w.scl[i], gs[i]);
        fail_count++;
      end
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      world_q.delete();
      for (int i = 0; i < 3; i++) begin
        world.pos[i] = '0;
        world.ang[i] = '0;
        world.scl[i] = 16'sd256;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) check_world();
      if (in_ch.valid && in_ch.ready) predict_world();
    end
    pending = world_q.size();
  end

endmodule

// File: bench/tb_euler_trs_chain_compose.sv
// ---------------------------------------------------------------------------
// Euler TRS chain compose testbench
// Sends directed and random local transforms with random gaps and output
// stalls, including one long output hold-off; the checker gives the verdict.
// ---------------------------------------------------------------------------
module tb_euler_trs_chain_compose;

  localparam int     N_RANDOM  = 700;
  localparam longint CYC_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   sent_all = 1'b0;
  longint cycles = 0;

  etc_in_if  in_ch ();
  etc_out_if out_ch ();

  euler_trs_chain_compose #(.TRIG_BITS(16)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  etc_checker #(.TRIG_BITS(16)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.pos_x     = '0;
    in_ch.pos_y     = '0;
    in_ch.pos_z     = '0;
    in_ch.angle_x   = '0;
    in_ch.angle_y   = '0;
    in_ch.angle_z   = '0;
    in_ch.scale_x   = '0;
    in_ch.scale_y   = '0;
    in_ch.scale_z   = '0;
    out_ch.ready    = 1'b0;
  end

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 1024)) - 16'd512;
    endcase
  endfunction

  task automatic send_item(input logic st, input logic [31:0] px, py, pz,
                           input logic [15:0] ax, ay, az,
                           input logic [15:0] sx, sy, sz, input int gap);
    in_ch.start_req <= st;
    in_ch.pos_x     <= px;
    in_ch.pos_y     <= py;
    in_ch.pos_z     <= pz;
    in_ch.angle_x   <= ax;
    in_ch.angle_y   <= ay;
    in_ch.angle_z   <= az;
    in_ch.scale_x   <= sx;
    in_ch.scale_y   <= sy;
    in_ch.scale_z   <= sz;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int gap);
    send_item($urandom_range(0, 7) == 0, rand_pos(), rand_pos(), rand_pos(),
              16'($urandom), 16'($urandom), 16'($urandom),
              rand_scale(), rand_scale(), rand_scale(), gap);
  endtask

  // sender
  initial begin
    int gap;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // compose onto the reset identity, no start seen yet
    send_item(1'b0, 32'h00010000, 32'h00020000, 32'hfffd0000,
              16'd0, 16'd16384, 16'd65535, 16'h0100, 16'h0200, 16'h0080, 0);
    send_item(1'b1, 32'h7fffffff, 32'h80000000, 32'd0,
              16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'h8000, 1);
    // position and scale saturation
    send_item(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              16'd65535, 16'd32768, 16'd49152, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send_item(1'b0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              16'd1, 16'd16383, 16'd32767, 16'h8000, 16'h8000, 16'h0000, 2);
    // each quadrant and its boundaries
    send_item(1'b1, 32'd0, 32'd0, 32'd0,
              16'd16384, 16'd32768, 16'd49152, 16'h0100, 16'h0100, 16'h0100, 0);
    send_item(1'b0, 32'h00010000, 32'h00010000, 32'h00010000,
              16'd65535, 16'd65535, 16'd65535, 16'h0100, 16'h0100, 16'h0100, 0);
    send_item(1'b0, 32'h00010000, 32'hffff0000, 32'h00008000,
              16'd1, 16'd8192, 16'd24576, 16'hff00, 16'h0180, 16'h0040, 3);
    send_item(1'b0, 32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
              16'd40960, 16'd57344, 16'd0, 16'h00ff, 16'h0101, 16'hffff, 0);
    send_item(1'b1, 32'hffffffff, 32'h00000001, 32'h55555555,
              16'hffff, 16'h8000, 16'h4000, 16'h0001, 16'hffff, 16'h0100, 0);
    send_item(1'b0, 32'hffffffff, 32'h80000000, 32'haaaaaaaa,
              16'h5555, 16'haaaa, 16'hc000, 16'h0100, 16'h0100, 16'h0100, 0);
    for (int n = 0; n < N_RANDOM; n++) begin
      gap = ((n / 60) % 3 == 2) ? 0 : $urandom_range(0, 9);
      send_random(gap);
    end
    in_ch.valid <= 1'b0;
    sent_all = 1'b1;
  end

  // receiver, with one long hold-off first
  initial begin
    int wait_cyc;
    int k;
    k = 0;
    @(negedge rst);
    repeat (6000) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      k++;
      wait_cyc = ((k / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
      if (wait_cyc > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cyc) @(posedge clk);
      end
    end
  end

  // verdict
  initial begin
    wait (sent_all);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
